@@ hw/rtl/sva_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator package
// Request codes, field widths and the lowest-set-bit encoder.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int unsigned ReqW   = 2;
  localparam int unsigned VoiceW = 4;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned AgeW   = 8;

  typedef enum logic [ReqW-1:0] {
    ReqUpdate  = 2'd0,
    ReqAlloc   = 2'd1,
    ReqRelease = 2'd2
  } req_e;

  // Index of the lowest set bit, zero for an empty mask.
  function automatic logic [VoiceW-1:0] lowest_idx(input logic [MaskW-1:0] m);
    logic [VoiceW-1:0] r;
    r = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = VoiceW'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/sva_age_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice age store
// One-port-write, one-port-read age memory with registered read data.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module sva_age_mem
  import sva_pkg::*;
#(
  parameter int unsigned VOICES = 8,
  parameter int unsigned IdxW   = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  logic [AgeW-1:0]   wr_data_i,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  output logic [AgeW-1:0]   rd_data_o
);

  logic [AgeW-1:0]   mem [VOICES];
  logic [VOICES-1:0] written_q;
  logic [AgeW-1:0]   rd_data_q;
  logic              rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

@@ hw/rtl/synth_voice_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Synthesizer voice allocator
// Update, allocate and release requests on a valid/ready input channel;
// one result word per request on a valid/ready output channel.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word carries req_type and its operands. Update, release,
//   unused codes and an allocate that finds a free or releasing voice
//   complete in the accept cycle, with the result valid the next cycle.
//   An allocate that must steal scans the age memory one voice per cycle:
//   the scan state reads all VOICES entries, a wait state lets the last
//   read arrive and the finish state stamps the stolen voice, waiting
//   until the previous result is taken. The single read port of the age
//   memory makes the scan serial. One request is in flight at a time.
//   The result sits in an output register; a new word is accepted while
//   the previous result is taken in the same cycle. When the receiver
//   stalls, the result holds and the input stops accepting.
//   Reset clears masks, age counter and all ages (entries never written
//   read as age zero); no clearing pass is needed, the block is ready
//   as soon as reset is released.
// ----------------------------------------------------------------------------
module synth_voice_allocator_unit
  import sva_pkg::*;
#(
  parameter int unsigned VOICES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic              mask_valid_i,
  input  logic [MaskW-1:0]  new_sounding_mask_i,
  input  logic [VoiceW-1:0] voice_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VoiceW-1:0] voice_o,
  output logic              voice_valid_o,
  output logic [MaskW-1:0]  sounding_mask_o,
  output logic [MaskW-1:0]  gated_mask_o
);

  localparam int unsigned IdxW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [MaskW-1:0] VoiceMask = MaskW'((32'd1 << VOICES) - 32'd1);
  localparam logic [IdxW-1:0]  LastIdx   = IdxW'(VOICES - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [MaskW-1:0]  sounding_q, sounding_d;
  logic [MaskW-1:0]  working_q, working_d;
  logic [MaskW-1:0]  gate_q, gate_d;
  logic [AgeW-1:0]   age_cnt_q, age_cnt_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic              rd_pend_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              found_q, found_d;
  logic [IdxW-1:0]   oldest_idx_q, oldest_idx_d;
  logic [AgeW-1:0]   oldest_age_q, oldest_age_d;

  logic              out_valid_q, out_valid_d;
  logic [VoiceW-1:0] voice_q, voice_d;
  logic              voice_valid_q, voice_valid_d;
  logic [MaskW-1:0]  out_sound_q, out_sound_d;
  logic [MaskW-1:0]  out_gate_q, out_gate_d;

  logic              accept;
  logic              out_free;
  logic [MaskW-1:0]  free_mask;
  logic [MaskW-1:0]  rel_mask;
  logic [VoiceW-1:0] pick;
  logic [MaskW-1:0]  pick_bit;
  logic [MaskW-1:0]  new_sound;
  logic              rd_en;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [AgeW-1:0]   rd_age;
  logic [AgeW-1:0]   age_diff;

  sva_age_mem #(
    .VOICES (VOICES),
    .IdxW   (IdxW)
  ) u_age_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (age_cnt_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_q),
    .rd_data_o (rd_age)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign free_mask = ~working_q & ~gate_q & VoiceMask;
  assign rel_mask  = working_q & ~gate_q & VoiceMask;
  assign pick      = (|free_mask) ? lowest_idx(free_mask) : lowest_idx(rel_mask);
  assign pick_bit  = MaskW'(1) << pick;
  assign new_sound = mask_valid_i ? new_sounding_mask_i : sounding_q;
  assign age_diff  = rd_age - oldest_age_q;

  // Reads happen only in the scan state, writes only at accept or finish,
  // so the memory never sees a read and a write to the same entry at once.
  assign rd_en = (state_q == StScan);

  always_comb begin
    state_d       = state_q;
    sounding_d    = sounding_q;
    working_d     = working_q;
    gate_d        = gate_q;
    age_cnt_d     = age_cnt_q;
    scan_d        = scan_q;
    found_d       = found_q;
    oldest_idx_d  = oldest_idx_q;
    oldest_age_d  = oldest_age_q;
    wr_en         = 1'b0;
    wr_addr       = pick[IdxW-1:0];
    out_valid_d   = out_valid_q && !out_ready_i;
    voice_d       = voice_q;
    voice_valid_d = voice_valid_q;
    out_sound_d   = out_sound_q;
    out_gate_d    = out_gate_q;

    // Fold in one aged entry per cycle while the scan is running.
    if (rd_pend_q && gate_q[rd_idx_q]) begin
      if (!found_q || age_diff[AgeW-1]) begin
        found_d      = 1'b1;
        oldest_idx_d = rd_idx_q;
        oldest_age_d = rd_age;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          out_valid_d   = 1'b1;
          voice_d       = '0;
          voice_valid_d = 1'b0;
          case (req_type_i)
            ReqUpdate: begin
              sounding_d = new_sound;
              working_d  = new_sound;
            end
            ReqAlloc: begin
              if (|(free_mask | rel_mask)) begin
                working_d     = working_q | pick_bit;
                gate_d        = gate_q | pick_bit;
                wr_en         = 1'b1;
                age_cnt_d     = age_cnt_q + AgeW'(1);
                voice_d       = pick;
                voice_valid_d = 1'b1;
              end else begin
                // Every voice is gated: steal the oldest.
                out_valid_d = out_valid_q && !out_ready_i;
                scan_d      = '0;
                found_d     = 1'b0;
                state_d     = StScan;
              end
            end
            ReqRelease: begin
              if ({1'b0, voice_index_i} < (VoiceW + 1)'(VOICES)) begin
                gate_d = gate_q & ~(MaskW'(1) << voice_index_i);
              end
            end
            default: ;
          endcase
          out_sound_d = sounding_d;
          out_gate_d  = gate_d;
        end
      end
      StScan: begin
        if (scan_q == LastIdx) begin
          state_d = StWait;
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end
      StWait: begin
        state_d = StFin;
      end
      StFin: begin
        wr_addr = oldest_idx_q;
        if (out_free) begin
          wr_en         = 1'b1;
          age_cnt_d     = age_cnt_q + AgeW'(1);
          out_valid_d   = 1'b1;
          voice_d       = VoiceW'(oldest_idx_q);
          voice_valid_d = 1'b1;
          out_sound_d   = sounding_q;
          out_gate_d    = gate_q;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sounding_q  <= '0;
      working_q   <= '0;
      gate_q      <= '0;
      age_cnt_q   <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sounding_q  <= sounding_d;
      working_q   <= working_d;
      gate_q      <= gate_d;
      age_cnt_q   <= age_cnt_d;
      rd_pend_q   <= rd_en;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q        <= scan_d;
    rd_idx_q      <= scan_q;
    oldest_idx_q  <= oldest_idx_d;
    oldest_age_q  <= oldest_age_d;
    voice_q       <= voice_d;
    voice_valid_q <= voice_valid_d;
    out_sound_q   <= out_sound_d;
    out_gate_q    <= out_gate_d;
  end

  assign out_valid_o     = out_valid_q;
  assign voice_o         = voice_q;
  assign voice_valid_o   = voice_valid_q;
  assign sounding_mask_o = out_sound_q;
  assign gated_mask_o    = out_gate_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gate_q & ~VoiceMask) == '0)
    else $error("gate bit set above the voice count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> ((gate_q & VoiceMask) == VoiceMask))
    else $error("steal scan started with an ungated voice");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin) |-> found_q)
    else $error("steal scan finished without a candidate");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && voice_valid_q) |-> out_gate_q[voice_q])
    else $error("allocated voice not gated in result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("age memory read and write in the same cycle");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives update, allocate, release and unused-code words into synth_voice_allocator_unit
// and tracks the masks, gates and ages in a scoreboard. Each result word is
// compared field by field with the oldest prediction. The test runs through
// phases of sender idling and receiver stalling, including a long receiver
// hold-off and a drain after every phase.
// ----------------------------------------------------------------------------
module tb_top;
  import sva_pkg::*;

  localparam int unsigned NumVoices = 8;
  localparam int unsigned PhaseWords = 425;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  typedef struct packed {
    logic [VoiceW-1:0] voice;
    logic              voice_valid;
    logic [MaskW-1:0]  sounding;
    logic [MaskW-1:0]  gated;
  } alloc_result_t;

  class voice_tracker;
    logic [MaskW-1:0] sounding;
    logic [MaskW-1:0] working;
    logic [MaskW-1:0] gated;
    logic [AgeW-1:0]  age [NumVoices];
    logic [AgeW-1:0]  age_count;
    alloc_result_t    pending_results[$];
    int               mismatches;

    function new();
      sounding   = '0;
      working    = '0;
      gated      = '0;
      age_count  = '0;
      mismatches = 0;
      foreach (age[v]) age[v] = '0;
    endfunction

    function automatic alloc_result_t predict_voice(logic [ReqW-1:0] req, logic mv,
                                                    logic [MaskW-1:0] nm,
                                                    logic [VoiceW-1:0] idx);
      alloc_result_t   r;
      logic            found;
      int              pick;
      logic [AgeW-1:0] diff;
      r     = '0;
      found = 1'b0;
      pick  = 0;
      case (req)
        ReqUpdate: begin
          if (mv) sounding = nm;
          working = sounding;
        end
        ReqAlloc: begin
          // free voices first, then voices in release
          for (int v = 0; v < NumVoices && !found; v++) begin
            if (!working[v] && !gated[v]) begin
              found = 1'b1;
              pick  = v;
            end
          end
          for (int v = 0; v < NumVoices && !found; v++) begin
            if (working[v] && !gated[v]) begin
              found = 1'b1;
              pick  = v;
            end
          end
          if (found) begin
            working[pick] = 1'b1;
            gated[pick]   = 1'b1;
          end else begin
            // steal the oldest gated voice, ages compared modulo 256
            for (int v = 0; v < NumVoices; v++) begin
              if (gated[v]) begin
                if (!found) begin
                  found = 1'b1;
                  pick  = v;
                end else begin
                  diff = age[v] - age[pick];
                  if (diff[AgeW-1]) pick = v;
                end
              end
            end
          end
          if (found) begin
            age[pick]     = age_count;
            age_count     = age_count + 1'b1;
            r.voice       = VoiceW'(pick);
            r.voice_valid = 1'b1;
          end
        end
        ReqRelease: begin
          if (idx < NumVoices) gated[idx] = 1'b0;
        end
        default: ;
      endcase
      r.sounding = sounding;
      r.gated    = gated;
      return r;
    endfunction

    function void note_request(logic [ReqW-1:0] req, logic mv, logic [MaskW-1:0] nm,
                               logic [VoiceW-1:0] idx);
      pending_results.push_back(predict_voice(req, mv, nm, idx));
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name,
                 exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(logic [VoiceW-1:0] voice, logic voice_valid,
                               logic [MaskW-1:0] sounding_mask, logic [MaskW-1:0] gated_mask);
      alloc_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual voice %0d valid %0d",
                 $time, voice, voice_valid);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("voice", exp_r.voice, voice);
      compare_field("voice_valid", exp_r.voice_valid, voice_valid);
      compare_field("sounding_mask", exp_r.sounding, sounding_mask);
      compare_field("gated_mask", exp_r.gated, gated_mask);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ReqW-1:0]   req_type_i;
  logic              mask_valid_i;
  logic [MaskW-1:0]  new_sounding_mask_i;
  logic [VoiceW-1:0] voice_index_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [VoiceW-1:0] voice_o;
  logic              voice_valid_o;
  logic [MaskW-1:0]  sounding_mask_o;
  logic [MaskW-1:0]  gated_mask_o;

  voice_tracker tracker;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  logic         hold_request;
  int unsigned  hold_left;
  int unsigned  cycle_count;

  synth_voice_allocator_unit #(
    .VOICES(NumVoices)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .mask_valid_i       (mask_valid_i),
    .new_sounding_mask_i(new_sounding_mask_i),
    .voice_index_i      (voice_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .voice_o            (voice_o),
    .voice_valid_o      (voice_valid_o),
    .sounding_mask_o    (sounding_mask_o),
    .gated_mask_o       (gated_mask_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    hold_request   = 1'b0;
    hold_left      = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.check_result(voice_o, voice_valid_o, sounding_mask_o, gated_mask_o);
      end
      if (in_valid_i && in_ready_o) begin
        tracker.note_request(req_type_i, mask_valid_i, new_sounding_mask_i, voice_index_i);
      end
    end
  end

  // Leave valid high across back-to-back words; drop it only to idle.
  task automatic send_word(logic [ReqW-1:0] req, logic mv, logic [MaskW-1:0] nm,
                           logic [VoiceW-1:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i          <= 1'b1;
    req_type_i          <= req;
    mask_valid_i        <= mv;
    new_sounding_mask_i <= nm;
    voice_index_i       <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    int unsigned       pick;
    logic [ReqW-1:0]   req;
    logic [VoiceW-1:0] idx;
    pick = $urandom_range(99);
    if (pick < 35) req = ReqAlloc;
    else if (pick < 70) req = ReqRelease;
    else if (pick < 95) req = ReqUpdate;
    else req = ReqUnused;
    // mostly in-range releases so gates do not saturate
    if ($urandom_range(99) < 80) idx = VoiceW'($urandom_range(NumVoices - 1));
    else idx = VoiceW'($urandom_range(15));
    send_word(req, 1'($urandom_range(1)), MaskW'($urandom_range(16'hFFFF)), idx);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0);
  endtask

  task automatic run_directed();
    send_word(ReqUpdate, 1'b1, 16'hFFFF, 4'd0);
    // all sounding, none gated: take voices in release
    repeat (3) send_word(ReqAlloc, 1'b1, 16'h0000, 4'hF);
    send_word(ReqUpdate, 1'b0, 16'h0000, 4'hF);
    send_word(ReqUpdate, 1'b1, 16'h0000, 4'd0);
    send_word(ReqAlloc, 1'b0, 16'hFFFF, 4'd0);
    send_word(ReqRelease, 1'b1, 16'hFFFF, 4'd15);
    send_word(ReqRelease, 1'b0, 16'h0000, 4'd8);
    send_word(ReqRelease, 1'b0, 16'h0000, 4'd0);
    send_word(ReqRelease, 1'b0, 16'h0000, 4'd7);
    send_word(ReqUnused, 1'b1, 16'hFFFF, 4'd3);
    // fill every voice, then steal five times
    repeat (10) send_word(ReqAlloc, 1'b0, 16'h0000, 4'd0);
    send_word(ReqUpdate, 1'b1, 16'h5A00, 4'd0);
    send_word(ReqAlloc, 1'b1, 16'hFFFF, 4'hF);
  endtask

  initial begin
    tracker = new();
    rst_ni              <= 1'b0;
    in_valid_i          <= 1'b0;
    req_type_i          <= ReqUpdate;
    mask_valid_i        <= 1'b0;
    new_sounding_mask_i <= '0;
    voice_index_i       <= '0;
    out_ready_i         <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_for_results();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int i = 0; i < PhaseWords; i++) begin
        // hold off the receiver while words keep coming
        if (p == 0 && i == 100) hold_request = 1'b1;
        send_random();
      end
      wait_for_results();
    end
    repeat (16) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sva_pkg.sv
hw/rtl/sva_age_mem.sv
hw/rtl/synth_voice_allocator_unit.sv
verif/tb_top.sv
